/* rtl/emlchk_pkg.sv */
// Shared types and codes for the email address syntax checker.
// Depends on nothing; used by emlchk_verdict and the top level.
package emlchk_pkg;

  // Sticky flags kept for one part of the address (user or domain).
  typedef struct packed {
    logic nonempty;
    logic dbl_dot;
    logic trail_dot;
    logic lead_dot;
    logic has_dot;
    logic illegal;
  } part_flags_t;

  // Error codes, in priority order.
  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_MANY_AT       = 4'd1;
  localparam logic [3:0] ERR_NO_AT         = 4'd2;
  localparam logic [3:0] ERR_EMPTY_PART    = 4'd3;
  localparam logic [3:0] ERR_USER_CHAR     = 4'd4;
  localparam logic [3:0] ERR_USER_NO_DOT   = 4'd5;
  localparam logic [3:0] ERR_DOMAIN_CHAR   = 4'd6;
  localparam logic [3:0] ERR_DOMAIN_NO_DOT = 4'd7;
  localparam logic [3:0] ERR_USER_LEAD     = 4'd8;
  localparam logic [3:0] ERR_USER_TRAIL    = 4'd9;
  localparam logic [3:0] ERR_USER_DOUBLE   = 4'd10;
  localparam logic [3:0] ERR_DOMAIN_LEAD   = 4'd11;
  localparam logic [3:0] ERR_DOMAIN_TRAIL  = 4'd12;
  localparam logic [3:0] ERR_DOMAIN_DOUBLE = 4'd13;

endpackage

/* rtl/emlchk_verdict.sv */
// Priority encoder that turns the sticky part flags into an error code.
// Depends on emlchk_pkg (part_flags_t, error codes).
module emlchk_verdict (
  input  logic [1:0]               at_sign_count,
  input  emlchk_pkg::part_flags_t  user_flags,
  input  emlchk_pkg::part_flags_t  domain_flags,
  output logic [3:0]               error_code
);

  // First failing check wins
  always_comb begin
    priority if (at_sign_count >= 2'd2) begin
      error_code = emlchk_pkg::ERR_MANY_AT;
    end else if (at_sign_count == 2'd0) begin
      error_code = emlchk_pkg::ERR_NO_AT;
    end else if (!user_flags.nonempty || !domain_flags.nonempty) begin
      error_code = emlchk_pkg::ERR_EMPTY_PART;
    end else if (user_flags.illegal) begin
      error_code = emlchk_pkg::ERR_USER_CHAR;
    end else if (!user_flags.has_dot) begin
      error_code = emlchk_pkg::ERR_USER_NO_DOT;
    end else if (domain_flags.illegal) begin
      error_code = emlchk_pkg::ERR_DOMAIN_CHAR;
    end else if (!domain_flags.has_dot) begin
      error_code = emlchk_pkg::ERR_DOMAIN_NO_DOT;
    end else if (user_flags.lead_dot) begin
      error_code = emlchk_pkg::ERR_USER_LEAD;
    end else if (user_flags.trail_dot) begin
      error_code = emlchk_pkg::ERR_USER_TRAIL;
    end else if (user_flags.dbl_dot) begin
      error_code = emlchk_pkg::ERR_USER_DOUBLE;
    end else if (domain_flags.lead_dot) begin
      error_code = emlchk_pkg::ERR_DOMAIN_LEAD;
    end else if (domain_flags.trail_dot) begin
      error_code = emlchk_pkg::ERR_DOMAIN_TRAIL;
    end else if (domain_flags.dbl_dot) begin
      error_code = emlchk_pkg::ERR_DOMAIN_DOUBLE;
    end else begin
      error_code = emlchk_pkg::ERR_NONE;
    end
  end

endmodule

/* rtl/email_address_syntax_checker.sv */
// Email address syntax checker, top level.
// A verdict appears in the cycle after the end-marker transaction is accepted.
// Throughput: one byte per cycle; the byte side stalls only while a verdict waits
// in the output register and the consumer stalls it.
// Reset (rst, synchronous, active high) clears the flags, the @ count and the verdict valid.
// Depends on emlchk_pkg and emlchk_verdict.
module email_address_syntax_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] char_byte,
  input  logic       is_end,
  output logic       verdict_valid,
  input  logic       verdict_stall,
  output logic       is_valid,
  output logic [3:0] error_code
);

  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39);
  endfunction

  logic [1:0]              at_sign_count, at_sign_count_next;
  emlchk_pkg::part_flags_t user_flags, user_flags_next;
  emlchk_pkg::part_flags_t domain_flags, domain_flags_next;
  emlchk_pkg::part_flags_t cur_flags;
  emlchk_pkg::part_flags_t domain_closed;
  logic                    previous_was_dot, previous_was_dot_next;
  logic                    part_has_chars, part_has_chars_next;
  logic                    byte_accept;
  logic [3:0]              code_now;

  // Stall only when the verdict register is full and held
  assign byte_stall  = verdict_valid && verdict_stall;
  assign byte_accept = byte_valid && !byte_stall;

  // Domain part closed at the end marker (only with exactly one @)
  always_comb begin
    domain_closed = domain_flags;
    if (at_sign_count == 2'd1) begin
      domain_closed.trail_dot = domain_flags.trail_dot | previous_was_dot;
      domain_closed.nonempty  = domain_flags.nonempty | part_has_chars;
    end
  end

  emlchk_verdict u_verdict (
    .at_sign_count (at_sign_count),
    .user_flags    (user_flags),
    .domain_flags  (domain_closed),
    .error_code    (code_now)
  );

  // Per-byte flag update
  always_comb begin
    at_sign_count_next    = at_sign_count;
    user_flags_next       = user_flags;
    domain_flags_next     = domain_flags;
    previous_was_dot_next = previous_was_dot;
    part_has_chars_next   = part_has_chars;
    cur_flags             = (at_sign_count == 2'd0) ? user_flags : domain_flags;
    if (byte_accept) begin
      if (is_end) begin
        at_sign_count_next    = 2'd0;
        user_flags_next       = '0;
        domain_flags_next     = '0;
        previous_was_dot_next = 1'b0;
        part_has_chars_next   = 1'b0;
      end else if (char_byte == CHAR_AT) begin
        if (at_sign_count == 2'd0) begin
          user_flags_next.trail_dot = user_flags.trail_dot | previous_was_dot;
          user_flags_next.nonempty  = user_flags.nonempty | part_has_chars;
          previous_was_dot_next     = 1'b0;
          part_has_chars_next       = 1'b0;
        end
        if (at_sign_count != 2'd2) begin
          at_sign_count_next = at_sign_count + 2'd1;
        end
      end else begin
        if (char_byte == CHAR_DOT) begin
          cur_flags.has_dot = 1'b1;
          if (!part_has_chars) begin
            cur_flags.lead_dot = 1'b1;
          end
          if (previous_was_dot) begin
            cur_flags.dbl_dot = 1'b1;
          end
          previous_was_dot_next = 1'b1;
        end else begin
          if (!(is_alnum(char_byte) ||
                (at_sign_count == 2'd0 && char_byte == CHAR_UNDER))) begin
            cur_flags.illegal = 1'b1;
          end
          previous_was_dot_next = 1'b0;
        end
        part_has_chars_next = 1'b1;
        if (at_sign_count == 2'd0) begin
          user_flags_next = cur_flags;
        end else begin
          domain_flags_next = cur_flags;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      at_sign_count    <= 2'd0;
      user_flags       <= '0;
      domain_flags     <= '0;
      previous_was_dot <= 1'b0;
      part_has_chars   <= 1'b0;
    end else begin
      at_sign_count    <= at_sign_count_next;
      user_flags       <= user_flags_next;
      domain_flags     <= domain_flags_next;
      previous_was_dot <= previous_was_dot_next;
      part_has_chars   <= part_has_chars_next;
    end
  end

  // Verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (byte_accept && is_end) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept && is_end) begin
      error_code <= code_now;
      is_valid   <= (code_now == emlchk_pkg::ERR_NONE);
    end
  end

  // Checks
  a_end_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    byte_accept && is_end |=> verdict_valid)
    else $error("end transaction did not produce a verdict");

  a_end_clears_state: assert property (@(posedge clk) disable iff (rst)
    byte_accept && is_end |=> at_sign_count == 2'd0 && !previous_was_dot &&
                              !part_has_chars && user_flags == '0 && domain_flags == '0)
    else $error("state not cleared after end transaction");

  a_at_count_saturates: assert property (@(posedge clk) disable iff (rst)
    at_sign_count != 2'd3)
    else $error("at sign count passed saturation");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> error_code <= emlchk_pkg::ERR_DOMAIN_DOUBLE &&
                      is_valid == (error_code == emlchk_pkg::ERR_NONE))
    else $error("verdict code out of range or inconsistent");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !verdict_valid |-> !byte_stall)
    else $error("byte side stalled with empty verdict register");

endmodule
